// File: rtl/sdkl_pkg.sv
// Shared types and constants for the sorted date-keyed list.
// Used by sdkl_cell and sorted_date_keyed_list; no dependencies.
`default_nettype none

package sdkl_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [11:0]         year;
		logic [3:0]          month;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic   ins_en;
		logic   del_en;
		entry_t item;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/sdkl_cell.sv
// One slot of the sorted list: holds an entry, compares against the broadcast item,
// shifts toward or from its neighbors. Depends on sdkl_pkg.
`default_nettype none

module sdkl_cell (
	input  wire logic              clk,
	input  wire sdkl_pkg::cell_ctl_t ctl,
	input  wire logic              valid,       // slot holds an entry
	input  wire logic              prev_valid,
	input  wire logic              prev_shift,  // lower neighbor moves up
	input  wire sdkl_pkg::entry_t  prev_entry,
	input  wire sdkl_pkg::entry_t  next_entry,
	input  wire logic              hit_in,      // key matched below this slot
	output sdkl_pkg::entry_t       entry,
	output logic                   shift,
	output logic                   hit_out
);
	import sdkl_pkg::*;

	entry_t entry_q;
	entry_t entry_d;
	logic   sorts_ahead;
	logic   match;
	logic   load;

	// new date sorts ahead of this slot's date; equal dates stay behind
	assign sorts_ahead = (ctl.item.year < entry_q.year) ||
		((ctl.item.year == entry_q.year) && (ctl.item.month < entry_q.month));
	assign shift   = valid && sorts_ahead;
	assign match   = valid && (entry_q.key == ctl.item.key);
	assign hit_out = hit_in || match;
	assign entry   = entry_q;

	always_comb begin
		entry_d = entry_q;
		load    = 1'b0;
		if (ctl.ins_en) begin
			if (prev_shift) begin
				entry_d = prev_entry;
				load    = 1'b1;
			end else if (shift || (!valid && prev_valid)) begin
				entry_d = ctl.item;
				load    = 1'b1;
			end
		end else if (ctl.del_en && hit_out) begin
			// close the gap: pull from the upper neighbor
			entry_d = next_entry;
			load    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= entry_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sorted_date_keyed_list.sv
// Top level of the sorted date-keyed list: stream ports, op register, cell chain, result.
// Depends on sdkl_pkg and sdkl_cell.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: key, year, month, position
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: count, key, year, month
//
// The op register takes the item; the cell row then compares it in parallel, shifts by one
// slot, and loads the result register. No new item is taken while an op is pending.
// The next item is taken while a result waits; execution waits for a free result slot.
// Reset clears the entry count, op and result valid; slot payload is not reset.
// A stalled output holds one item and one pending op; s_tready drops until it drains.

module sorted_date_keyed_list (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [87:0] s_tdata,   // member_key[63:0], birth_year[75:64],
	                                    // birth_month[79:76], position[83:80], zeros
	input  wire logic [1:0]  s_tuser,   // mode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // entry_count[4:0], out_key[68:5],
	                                    // out_year[80:69], out_month[84:81], zeros
	output logic [1:0]       m_tuser    // status[1:0]
);
	import sdkl_pkg::*;

	// pending op
	logic             op_pend_q;
	mode_t            op_mode_q;
	entry_t           op_item_q;
	logic [3:0]       op_pos_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	// result register
	logic             res_valid_q;
	status_t          res_status_q;
	logic [4:0]       res_count_q;
	entry_t           res_entry_q;

	logic             exec;
	logic             full;
	logic             ins_ok;
	logic             del_ok;
	logic             pos_ok;
	cell_ctl_t        ctl;
	entry_t           rd_entry;
	status_t          status_d;
	entry_t           res_entry_d;

	entry_t           cell_entry [CAPACITY];
	logic             cell_valid [CAPACITY+1];
	logic             cell_shift [CAPACITY+1];
	logic             hit        [CAPACITY+1];
	logic             rd_sel     [CAPACITY];

	assign s_tready = !op_pend_q;
	assign exec     = op_pend_q && (!res_valid_q || m_tready);
	assign full     = (32'(count_q) >= CAPACITY);
	assign ins_ok   = exec && (op_mode_q == MODE_INSERT) && !full;
	assign del_ok   = exec && (op_mode_q == MODE_DELETE) && hit[CAPACITY];
	assign pos_ok   = (32'(op_pos_q) < 32'(count_q));

	assign ctl.ins_en = ins_ok;
	assign ctl.del_en = del_ok;
	assign ctl.item   = op_item_q;

	// chain boundaries: slot 0 sees an always-valid, never-shifting lower neighbor
	assign cell_valid[0] = 1'b1;
	assign cell_shift[0] = 1'b0;
	assign hit[0]        = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   v;

		// slot i valid while i is below the count
		assign v = (i < 32'(count_q));
		assign cell_valid[i+1] = v;
		assign rd_sel[i] = (32'(op_pos_q) == i);

		if (i == 0) begin : g_first
			assign prev_e = '0;
		end else begin : g_mid
			assign prev_e = cell_entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end

		sdkl_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.valid     (v),
			.prev_valid(cell_valid[i]),
			.prev_shift(cell_shift[i]),
			.prev_entry(prev_e),
			.next_entry(next_e),
			.hit_in    (hit[i]),
			.entry     (cell_entry[i]),
			.shift     (cell_shift[i+1]),
			.hit_out   (hit[i+1])
		);
	end

	// read port: AND-OR select across the slots
	always_comb begin
		rd_entry = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_entry = rd_entry | (rd_sel[i] ? cell_entry[i] : '0);
		end
	end

	always_comb begin
		count_d     = count_q;
		status_d    = ST_OK;
		res_entry_d = '0;
		if (ins_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_d = count_q - CNT_W'(1);
		end
		case (op_mode_q)
			MODE_INSERT: status_d = full ? ST_FULL : ST_OK;
			MODE_DELETE: status_d = hit[CAPACITY] ? ST_OK : ST_NOT_FOUND;
			MODE_READ: begin
				if (pos_ok) begin
					res_entry_d = rd_entry;
				end else begin
					status_d = ST_EMPTY;
				end
			end
			default: status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_pend_q   <= 1'b0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				op_pend_q <= 1'b1;
			end else if (exec) begin
				op_pend_q <= 1'b0;
			end
			if (exec) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_mode_q       <= mode_t'(s_tuser);
			op_item_q.key   <= s_tdata[KEY_BITS-1:0];
			op_item_q.year  <= s_tdata[75:64];
			op_item_q.month <= s_tdata[79:76];
			op_pos_q        <= s_tdata[83:80];
		end
		if (exec) begin
			res_status_q <= status_d;
			res_count_q  <= 5'(count_d);
			res_entry_q  <= res_entry_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = {3'b000, res_entry_q.month, res_entry_q.year,
		64'(res_entry_q.key), res_count_q};

	// count stays within the slot row
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("entry count exceeds capacity");

	// a successful insert grows the list by exactly one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow count");

	// a successful delete shrinks the list by exactly one
	a_del_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		del_ok |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("delete did not shrink count");

	// a full report only comes with a full list
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_status_q == ST_FULL)) |-> (32'(count_q) == CAPACITY))
		else $error("full status with free slots");

	// no op is lost: a pending op stays pending until it executes
	a_op_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pend_q && !exec) |=> op_pend_q)
		else $error("pending op dropped");

endmodule

`default_nettype wire
